@@ design/mfc_pkg.sv @@
// Package for the floating code codec: field widths, codes and item types.
package mfc_pkg;

	localparam int EXP_BITS_W  = 2;
	localparam int MANT_BITS_W = 4;
	localparam int NUMBER_W    = 32;
	localparam int CODE_W      = 16;
	localparam int VALUE_W     = 23;
	localparam int EXP_BIAS    = 3;

	localparam int DEF_MAX_EXP_BITS  = 3;
	localparam int DEF_MAX_MANT_BITS = 12;

	// Mantissa field at its widest, the hidden one above it, the exponent field.
	localparam int MANT_W = 12;
	localparam int MFULL_W = MANT_W + 1;
	localparam int EX_W = 3;
	// Shift amount of the value: exponent plus bias, at most 10.
	localparam int SH_W = 4;
	// Bit position inside the clamped integer.
	localparam int POS_W = $clog2(VALUE_W);

	typedef enum logic {
		KIND_ENCODE = 1'b0,
		KIND_DECODE = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t                  kind;
		logic [EXP_BITS_W-1:0]  exp_bits;
		logic [MANT_BITS_W-1:0] mant_bits;
		logic [NUMBER_W-1:0]    number;
	} item_t;

	typedef struct packed {
		logic [CODE_W-1:0]  code;
		logic [VALUE_W-1:0] value;
	} result_t;

endpackage

@@ design/mfc_lead_one.sv @@
// Leading-one position of a word, found by a halving tree.
module mfc_lead_one #(
	parameter int WIDTH = mfc_pkg::VALUE_W
) (
	input  logic [WIDTH-1:0]         word,
	output logic [$clog2(WIDTH)-1:0] pos
);
	localparam int PW  = $clog2(WIDTH);
	localparam int PAD = 1 << PW;

	logic [PAD-1:0] rest;

	// Each level asks whether the upper half of what is left holds a one.
	always_comb begin
		rest = PAD'(word);
		pos  = '0;
		for (int k = PW - 1; k >= 0; k--) begin
			if ((rest >> (1 << k)) != '0) begin
				pos[k] = 1'b1;
				rest   = rest >> (1 << k);
			end
		end
	end

endmodule

@@ design/mfc_convert.sv @@
// Encode or decode of one item between the input and result registers.
module mfc_convert #(
	parameter int MAX_EXP_BITS  = mfc_pkg::DEF_MAX_EXP_BITS,
	parameter int MAX_MANT_BITS = mfc_pkg::DEF_MAX_MANT_BITS
) (
	input  mfc_pkg::item_t   item,
	output mfc_pkg::result_t result
);
	import mfc_pkg::*;

	logic [EXP_BITS_W-1:0]  e;
	logic [MANT_BITS_W-1:0] m;
	logic [EX_W-1:0]        emax;
	logic [CODE_W-1:0]      flag;
	logic [MANT_W-1:0]      mmask;
	logic [VALUE_W-1:0]     maxv;
	logic [VALUE_W-1:0]     numc;
	logic [POS_W-1:0]       lead;
	logic [POS_W-1:0]       shift;
	logic [CODE_W-1:0]      dmask;
	logic [CODE_W-1:0]      dcode;
	logic [MANT_W-1:0]      mant;
	logic [EX_W-1:0]        ex;
	logic [MFULL_W-1:0]     mant_full;
	logic [VALUE_W-1:0]     scaled;
	logic                   literal;

	// Widths outside the legal range are pulled to the nearest legal one.
	always_comb begin
		if (item.exp_bits == '0)
			e = EXP_BITS_W'(1);
		else if (item.exp_bits > EXP_BITS_W'(MAX_EXP_BITS))
			e = EXP_BITS_W'(MAX_EXP_BITS);
		else
			e = item.exp_bits;
		if (item.mant_bits == '0)
			m = MANT_BITS_W'(1);
		else if (item.mant_bits > MANT_BITS_W'(MAX_MANT_BITS))
			m = MANT_BITS_W'(MAX_MANT_BITS);
		else
			m = item.mant_bits;
	end

	assign emax  = EX_W'((4'd1 << e) - 4'd1);
	assign flag  = CODE_W'(1) << (5'(e) + 5'(m));
	assign mmask = MANT_W'((MFULL_W'(1) << m) - MFULL_W'(1));
	assign maxv  = VALUE_W'((14'd1 << (m + 4'd1)) - 14'd1) << (SH_W'(emax) + SH_W'(EXP_BIAS));
	assign numc  = (item.number > NUMBER_W'(maxv)) ? maxv : item.number[VALUE_W-1:0];

	mfc_lead_one #(.WIDTH(VALUE_W)) u_lead_one (
		.word (numc),
		.pos  (lead)
	);

	assign shift = lead - POS_W'(m);
	assign dmask = CODE_W'((17'(flag) << 1) - 17'd1);
	assign dcode = item.number[CODE_W-1:0] & dmask;

	// Mantissa and exponent for the shared value shifter, and whether the
	// item goes through literally instead.
	always_comb begin
		if (item.kind == KIND_ENCODE) begin
			literal = (numc < VALUE_W'(flag)) || (lead < POS_W'(5'(m) + 5'(EXP_BIAS)));
			mant    = MANT_W'(numc >> shift) & mmask;
			ex      = EX_W'(shift - POS_W'(EXP_BIAS)) & emax;
		end else begin
			literal = (dcode & flag) == '0;
			mant    = MANT_W'(dcode) & mmask;
			ex      = EX_W'(dcode >> m) & emax;
		end
	end

	assign mant_full = MFULL_W'(mant) | (MFULL_W'(1) << m);
	assign scaled    = VALUE_W'(mant_full) << (SH_W'(ex) + SH_W'(EXP_BIAS));

	always_comb begin
		if (item.kind == KIND_ENCODE) begin
			if (literal) begin
				result.code  = numc[CODE_W-1:0];
				result.value = numc;
			end else begin
				result.code  = flag | (CODE_W'(ex) << m) | CODE_W'(mant);
				result.value = scaled;
			end
		end else begin
			result.code  = dcode;
			result.value = literal ? VALUE_W'(dcode) : scaled;
		end
	end

endmodule

@@ design/mld_float_code_codec_core.sv @@
// Top level of the floating code codec: input register, converter, result register.
//
// Converts between plain integers and the exponential code |1|exp|mant| used
// in multicast listener reports. Each item carries its own field widths, so
// items of different formats may be mixed freely. kind selects encode
// (integer to code word) or decode (code word to integer); every item gives
// exactly one result holding the code word and the integer it stands for.
//
// Both channels use valid and stall; an item moves at a clock edge where
// valid is high and stall is low. The item is taken into the input
// register, converted by combinational logic, and the result lands in the
// result register that drives the output ports. One item is accepted
// every cycle as long as the receiver does not stall.
//
// When the receiver stalls, the result register holds its item and the
// input register still takes one more item; only when both are full does
// in_stall rise, and it falls in the same cycle that out_stall does.
// Reset empties both registers; no result is pending after reset.
module mld_float_code_codec_core #(
	parameter int MAX_EXP_BITS  = mfc_pkg::DEF_MAX_EXP_BITS,
	parameter int MAX_MANT_BITS = mfc_pkg::DEF_MAX_MANT_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            kind,
	input  logic [mfc_pkg::EXP_BITS_W-1:0]  exp_bits,
	input  logic [mfc_pkg::MANT_BITS_W-1:0] mant_bits,
	input  logic [mfc_pkg::NUMBER_W-1:0]    number,

	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [mfc_pkg::CODE_W-1:0]      code,
	output logic [mfc_pkg::VALUE_W-1:0]     value
);
	import mfc_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t result_s2;
	result_t result_c;
	logic    adv_s1;
	logic    adv_s2;

	// A stage loads when it is empty or when its content moves on.
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= in_valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	// Payload registers carry no reset; their valid bits guard them.
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			item_s1.kind      <= kind_t'(kind);
			item_s1.exp_bits  <= exp_bits;
			item_s1.mant_bits <= mant_bits;
			item_s1.number    <= number;
		end
		if (adv_s2 && valid_s1)
			result_s2 <= result_c;
	end

	mfc_convert #(
		.MAX_EXP_BITS  (MAX_EXP_BITS),
		.MAX_MANT_BITS (MAX_MANT_BITS)
	) u_convert (
		.item   (item_s1),
		.result (result_c)
	);

	assign out_valid = valid_s2;
	assign code      = result_s2.code;
	assign value     = result_s2.value;

endmodule
